// File: design/rtpp_pkg.sv
// Shared constants for the ring test pattern pixel generator.
package rtpp_pkg;

    localparam int MAX_DIM_DEF = 4096;

    localparam int COORD_W = 12;
    localparam int CFG_DIM_W = 13;
    localparam int TIME_W = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int PIXEL_W = 32;
    localparam int COLOR_W = 24;
    localparam int ALPHA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_TIME = 2'd2;

    localparam int RESET_WIDTH = 640;
    localparam int RESET_HEIGHT = 480;

    localparam int RADIUS_GAP = 8;
    localparam int RING_WIDTH = 32;
    localparam int STRIPE_HALF = 6;

    localparam int R2_SHIFT = 5;
    localparam int TIME_SHIFT_DISC = 6;
    localparam int TIME_SHIFT_RING = 5;
    localparam int TIME_SHIFT_OUTER = 4;

    localparam int MUL_SHIFT_MID = 10;
    localparam int MUL_SHIFT_HIGH = 19;

    localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 8'hff;
    localparam logic [ALPHA_W-1:0] ALPHA_CLEAR = 8'h00;

endpackage

// File: design/rtpp_cfg.sv
// Configuration registers for frame size and animation time.
module rtpp_cfg #(
    parameter int MAX_DIM = rtpp_pkg::MAX_DIM_DEF,
    parameter int DIM_W = rtpp_pkg::CFG_DIM_W
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rtpp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rtpp_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic [DIM_W-1:0]                    frame_width,
    output logic [DIM_W-1:0]                    frame_height,
    output logic [rtpp_pkg::TIME_W-1:0]         frame_time
);

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] width_next;
    logic [DIM_W-1:0] height_reg;
    logic [DIM_W-1:0] height_next;
    logic [rtpp_pkg::TIME_W-1:0] time_reg;
    logic [rtpp_pkg::TIME_W-1:0] time_next;
    logic [DIM_W-1:0] dim_raw;
    logic [DIM_W-1:0] dim_clamped;

    assign cfg_ready = 1'b1;

    assign dim_raw = DIM_W'(cfg_data[rtpp_pkg::CFG_DIM_W-1:0]);
    assign dim_clamped = (dim_raw > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : dim_raw;

    always_comb
    begin
        width_next = width_reg;
        height_next = height_reg;
        time_next = time_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rtpp_pkg::REG_FRAME_WIDTH:  width_next = dim_clamped;
                rtpp_pkg::REG_FRAME_HEIGHT: height_next = dim_clamped;
                rtpp_pkg::REG_FRAME_TIME:   time_next = cfg_data[rtpp_pkg::TIME_W-1:0];
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= DIM_W'(rtpp_pkg::RESET_WIDTH);
            height_reg <= DIM_W'(rtpp_pkg::RESET_HEIGHT);
            time_reg <= '0;
        end
        else
        begin
            width_reg <= width_next;
            height_reg <= height_next;
            time_reg <= time_next;
        end
    end

    assign frame_width = width_reg;
    assign frame_height = height_reg;
    assign frame_time = time_reg;

endmodule

// File: design/ring_test_pattern_pixel.sv
// Top level of the animated ring test pattern pixel generator.
//
// The block turns a pixel position into one 32-bit ARGB word. A request on the
// slave stream carries the column in s_tdata[11:0] and the row in s_tdata[23:12];
// the pixel leaves on the master stream in m_tdata. Frame width, frame height and
// the frame time value are written through the configuration channel, which is
// always ready; writes belong between frames while no request is in flight.
// The datapath is a four-stage pipeline: offsets and stripe test, squaring of
// offsets and radii, band selection, color product. An accepted request moves
// through s1_reg, s2_reg and s3_reg to pix_reg, which drives m_tdata. Unless
// the master side stalls, a new request may enter at every clock, so the rate
// is one pixel per cycle. The four squarers of the second stage set the depth.
// When the receiver stalls, each stage holds its data and empty stages still
// fill, so up to four pixels wait inside before s_tready falls; nothing is
// dropped or repeated. Reset empties the pipeline and loads a 640 by 480 frame
// with a frame time of zero.
module ring_test_pattern_pixel #(
    parameter int MAX_DIM = rtpp_pkg::MAX_DIM_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [2*rtpp_pkg::COORD_W-1:0]          s_tdata,   // col, row
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [rtpp_pkg::PIXEL_W-1:0]            m_tdata,   // pixel_value
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [rtpp_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [rtpp_pkg::CFG_DATA_W-1:0]         cfg_data
);

    localparam int DIM_BITS = $clog2(MAX_DIM + 1);
    localparam int DIM_W = (DIM_BITS > rtpp_pkg::CFG_DIM_W) ? DIM_BITS : rtpp_pkg::CFG_DIM_W;
    localparam int SW = DIM_W + 1;
    localparam int SQ_W = 2 * SW;
    localparam int R2_W = SQ_W + 1;
    localparam int CW = rtpp_pkg::COORD_W;
    localparam int COLOR_W = rtpp_pkg::COLOR_W;

    typedef struct packed {
        logic [CW-1:0]          x;
        logic [CW-1:0]          y;
        logic signed [SW-1:0]   dx;
        logic signed [SW-1:0]   dy;
        logic signed [SW-1:0]   outer;
        logic signed [SW-1:0]   inner;
        logic                   stripe;
    } st1_t;

    typedef struct packed {
        logic [CW-1:0]          x;
        logic [CW-1:0]          y;
        logic [SQ_W-1:0]        dx2;
        logic [SQ_W-1:0]        dy2;
        logic [SQ_W-1:0]        outer2;
        logic [SQ_W-1:0]        inner2;
        logic                   stripe;
    } st2_t;

    typedef struct packed {
        logic [COLOR_W-1:0]     base;
        logic                   stripe;
    } st3_t;

    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
    logic [rtpp_pkg::TIME_W-1:0] frame_time;

    logic v1_reg;
    logic v2_reg;
    logic v3_reg;
    logic v4_reg;
    logic rdy1;
    logic rdy2;
    logic rdy3;
    logic rdy4;

    st1_t s1_reg;
    st1_t s1_next;
    st2_t s2_reg;
    st2_t s2_next;
    st3_t s3_reg;
    st3_t s3_next;
    logic [rtpp_pkg::PIXEL_W-1:0] pix_reg;
    logic [rtpp_pkg::PIXEL_W-1:0] pix_next;

    logic [CW-1:0] in_x;
    logic [CW-1:0] in_y;
    logic signed [SW-1:0] xs;
    logic signed [SW-1:0] ys;
    logic signed [SW-1:0] hs;
    logic signed [SW-1:0] halfw;
    logic signed [SW-1:0] halfh;
    logic signed [SW-1:0] half_min;
    logic signed [SW-1:0] diag_a;
    logic signed [SW-1:0] diag_b;
    logic on_a;
    logic on_b;

    logic signed [SQ_W-1:0] p_dx;
    logic signed [SQ_W-1:0] p_dy;
    logic signed [SQ_W-1:0] p_outer;
    logic signed [SQ_W-1:0] p_inner;

    logic [R2_W-1:0] r2;
    logic [COLOR_W-1:0] t_disc;
    logic [COLOR_W-1:0] t_ring;
    logic [COLOR_W-1:0] t_outer;

    logic [COLOR_W-1:0] color;

    rtpp_cfg #(
        .MAX_DIM (MAX_DIM),
        .DIM_W   (DIM_W)
    ) u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .frame_width  (frame_width),
        .frame_height (frame_height),
        .frame_time   (frame_time)
    );

    assign rdy4 = !v4_reg || m_tready;
    assign rdy3 = !v3_reg || rdy4;
    assign rdy2 = !v2_reg || rdy3;
    assign rdy1 = !v1_reg || rdy2;
    assign s_tready = rdy1;

    // Stage 1: offsets from the center, radii and diagonal stripe test.
    always_comb
    begin
        in_x = s_tdata[CW-1:0];
        in_y = s_tdata[2*CW-1:CW];
        xs = $signed(SW'(in_x));
        ys = $signed(SW'(in_y));
        hs = $signed(SW'(frame_height));
        halfw = $signed(SW'(frame_width >> 1));
        halfh = $signed(SW'(frame_height >> 1));
        half_min = (halfw < halfh) ? halfw : halfh;
        diag_a = xs - ys;
        diag_b = xs + ys - hs;
        on_a = (diag_a <= SW'(rtpp_pkg::STRIPE_HALF))
            && (diag_a >= -$signed(SW'(rtpp_pkg::STRIPE_HALF)));
        on_b = (diag_b <= SW'(rtpp_pkg::STRIPE_HALF))
            && (diag_b >= -$signed(SW'(rtpp_pkg::STRIPE_HALF)));
        s1_next.x = in_x;
        s1_next.y = in_y;
        s1_next.dx = xs - halfw;
        s1_next.dy = ys - halfh;
        s1_next.outer = half_min - SW'(rtpp_pkg::RADIUS_GAP);
        s1_next.inner = half_min - SW'(rtpp_pkg::RADIUS_GAP + rtpp_pkg::RING_WIDTH);
        s1_next.stripe = on_a || on_b;
    end

    // Stage 2: squares of the offsets and of both radii.
    always_comb
    begin
        p_dx = s1_reg.dx * s1_reg.dx;
        p_dy = s1_reg.dy * s1_reg.dy;
        p_outer = s1_reg.outer * s1_reg.outer;
        p_inner = s1_reg.inner * s1_reg.inner;
        s2_next.x = s1_reg.x;
        s2_next.y = s1_reg.y;
        s2_next.dx2 = $unsigned(p_dx);
        s2_next.dy2 = $unsigned(p_dy);
        s2_next.outer2 = $unsigned(p_outer);
        s2_next.inner2 = $unsigned(p_inner);
        s2_next.stripe = s1_reg.stripe;
    end

    // Stage 3: band selection and the color base value.
    always_comb
    begin
        r2 = R2_W'(s2_reg.dx2) + R2_W'(s2_reg.dy2);
        t_disc = COLOR_W'(frame_time >> rtpp_pkg::TIME_SHIFT_DISC);
        t_ring = COLOR_W'(frame_time >> rtpp_pkg::TIME_SHIFT_RING);
        t_outer = COLOR_W'(frame_time >> rtpp_pkg::TIME_SHIFT_OUTER);
        if (r2 < R2_W'(s2_reg.inner2))
        begin
            s3_next.base = COLOR_W'(r2 >> rtpp_pkg::R2_SHIFT) + t_disc;
        end
        else if (r2 < R2_W'(s2_reg.outer2))
        begin
            s3_next.base = COLOR_W'(s2_reg.y) + t_ring;
        end
        else
        begin
            s3_next.base = COLOR_W'(s2_reg.x) + t_outer;
        end
        s3_next.stripe = s2_reg.stripe;
    end

    // Stage 4: the color multiplier has three set bits, so it is a shift and add.
    always_comb
    begin
        color = s3_reg.base
            + COLOR_W'(s3_reg.base << rtpp_pkg::MUL_SHIFT_MID)
            + COLOR_W'(s3_reg.base << rtpp_pkg::MUL_SHIFT_HIGH);
        pix_next = {s3_reg.stripe ? rtpp_pkg::ALPHA_CLEAR : rtpp_pkg::ALPHA_OPAQUE, color};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= s_tvalid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && s_tvalid)
        begin
            s1_reg <= s1_next;
        end
        if (rdy2 && v1_reg)
        begin
            s2_reg <= s2_next;
        end
        if (rdy3 && v2_reg)
        begin
            s3_reg <= s3_next;
        end
        if (rdy4 && v3_reg)
        begin
            pix_reg <= pix_next;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata = pix_reg;

endmodule

// File: design/rtpp_checker.sv
// Port-level checks for the ring test pattern pixel generator.
module rtpp_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 s_tvalid,
    input logic                                 s_tready,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [rtpp_pkg::PIXEL_W-1:0]         m_tdata,
    input logic                                 cfg_valid,
    input logic                                 cfg_ready
);

    localparam int AW = rtpp_pkg::ALPHA_W;
    localparam int PW = rtpp_pkg::PIXEL_W;

    // A stalled pixel stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
    else $error("m_tvalid dropped while stalled");

    // A stalled pixel keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("m_tdata changed while stalled");

    // The alpha byte is either fully opaque or fully clear.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[PW-1:PW-AW] == rtpp_pkg::ALPHA_OPAQUE)
            || (m_tdata[PW-1:PW-AW] == rtpp_pkg::ALPHA_CLEAR))
    else $error("alpha byte is neither opaque nor clear");

    // With the receiver ready while it passes the pipeline, an accepted request yields a pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
    else $error("pixel missing after pipeline latency");

    // The configuration channel never pushes back.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
    else $error("configuration request stalled");

endmodule

bind ring_test_pattern_pixel rtpp_checker u_rtpp_checker (.*);

// File: tb/sv/ring_pixel_checker.sv
`timescale 1ns / 1ps
// Pixel checker: watches all three channels, predicts each pixel and compares it.
module ring_pixel_checker #(
    parameter int MAX_DIM = rtpp_pkg::MAX_DIM_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_tvalid,
    input  logic                                    s_tready,
    input  logic [2*rtpp_pkg::COORD_W-1:0]          s_tdata,   // col, row
    input  logic                                    m_tvalid,
    input  logic                                    m_tready,
    input  logic [rtpp_pkg::PIXEL_W-1:0]            m_tdata,   // pixel_value
    input  logic                                    cfg_valid,
    input  logic                                    cfg_ready,
    input  logic [rtpp_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [rtpp_pkg::CFG_DATA_W-1:0]         cfg_data,
    output int                                      errors,
    output int                                      outstanding
);

    localparam logic [31:0] COLOR_MUL = 32'h0080401;
    localparam logic [31:0] COLOR_MASK = 32'h00ff_ffff;

    logic [rtpp_pkg::CFG_DIM_W-1:0] width_q = rtpp_pkg::CFG_DIM_W'(rtpp_pkg::RESET_WIDTH);
    logic [rtpp_pkg::CFG_DIM_W-1:0] height_q = rtpp_pkg::CFG_DIM_W'(rtpp_pkg::RESET_HEIGHT);
    logic [rtpp_pkg::TIME_W-1:0] time_q = '0;
    logic [rtpp_pkg::PIXEL_W-1:0] expected_pixels[$];
    logic [rtpp_pkg::PIXEL_W-1:0] want;

    function automatic logic [rtpp_pkg::CFG_DIM_W-1:0] saturate_dim(
        input logic [rtpp_pkg::CFG_DATA_W-1:0] value);
        logic [rtpp_pkg::CFG_DIM_W-1:0] dim;
        dim = value[rtpp_pkg::CFG_DIM_W-1:0];
        if (dim > MAX_DIM)
            dim = rtpp_pkg::CFG_DIM_W'(MAX_DIM);
        return dim;
    endfunction

    function automatic logic [rtpp_pkg::PIXEL_W-1:0] ring_pixel(
        input logic [rtpp_pkg::COORD_W-1:0] col,
        input logic [rtpp_pkg::COORD_W-1:0] row,
        input logic [rtpp_pkg::CFG_DIM_W-1:0] w,
        input logic [rtpp_pkg::CFG_DIM_W-1:0] h,
        input logic [rtpp_pkg::TIME_W-1:0] t);
        longint x;
        longint y;
        longint fh;
        longint halfw;
        longint halfh;
        longint outer;
        longint inner;
        longint dx;
        longint dy;
        longint r2;
        longint diag;
        longint anti;
        logic [31:0] base;
        logic [31:0] color;
        logic [rtpp_pkg::ALPHA_W-1:0] alpha;
        x = col;
        y = row;
        fh = h;
        halfw = w / 2;
        halfh = h / 2;
        outer = ((halfw < halfh) ? halfw : halfh) - rtpp_pkg::RADIUS_GAP;
        inner = outer - rtpp_pkg::RING_WIDTH;
        dx = x - halfw;
        dy = y - halfh;
        r2 = dx * dx + dy * dy;
        // The radii are squared as signed values, so a negative radius still
        // gives a positive band limit.
        if (r2 < inner * inner)
            base = 32'(r2 >> rtpp_pkg::R2_SHIFT) + (t >> rtpp_pkg::TIME_SHIFT_DISC);
        else if (r2 < outer * outer)
            base = 32'(y) + (t >> rtpp_pkg::TIME_SHIFT_RING);
        else
            base = 32'(x) + (t >> rtpp_pkg::TIME_SHIFT_OUTER);
        color = (base * COLOR_MUL) & COLOR_MASK;
        diag = x - y;
        if (diag < 0)
            diag = -diag;
        anti = x + y - fh;
        if (anti < 0)
            anti = -anti;
        alpha = (diag > rtpp_pkg::STRIPE_HALF && anti > rtpp_pkg::STRIPE_HALF)
            ? rtpp_pkg::ALPHA_OPAQUE : rtpp_pkg::ALPHA_CLEAR;
        return {alpha, color[rtpp_pkg::COLOR_W-1:0]};
    endfunction

    task automatic report(input string what, input logic [rtpp_pkg::PIXEL_W-1:0] got,
                          input logic [rtpp_pkg::PIXEL_W-1:0] exp_val);
        $display("%0t: %s: got %08h, wanted %08h", $time, what, got, exp_val);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_q = rtpp_pkg::CFG_DIM_W'(rtpp_pkg::RESET_WIDTH);
            height_q = rtpp_pkg::CFG_DIM_W'(rtpp_pkg::RESET_HEIGHT);
            time_q = '0;
            expected_pixels.delete();
            outstanding <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_pixels.size() == 0)
                    report("pixel with no request pending", m_tdata, '0);
                else
                begin
                    want = expected_pixels.pop_front();
                    if (m_tdata !== want)
                        report("pixel_value mismatch", m_tdata, want);
                end
            end
            if (s_tvalid && s_tready)
                expected_pixels.push_back(
                    ring_pixel(s_tdata[rtpp_pkg::COORD_W-1:0],
                               s_tdata[2*rtpp_pkg::COORD_W-1:rtpp_pkg::COORD_W],
                               width_q, height_q, time_q));
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    rtpp_pkg::REG_FRAME_WIDTH: width_q = saturate_dim(cfg_data);
                    rtpp_pkg::REG_FRAME_HEIGHT: height_q = saturate_dim(cfg_data);
                    rtpp_pkg::REG_FRAME_TIME: time_q = cfg_data;
                    default: ;
                endcase
            end
            outstanding <= expected_pixels.size();
        end
    end

endmodule

// File: tb/sv/ring_test_pattern_pixel_tb.sv
`timescale 1ns / 1ps
// Testbench top for the ring test pattern pixel generator: stimulus and verdict.
module ring_test_pattern_pixel_tb;

    localparam int DIM_LIMIT = rtpp_pkg::MAX_DIM_DEF;
    localparam int IDLE_LIMIT = 4000;
    localparam int RANDOM_PHASES = 13;
    localparam int PHASE_ITEMS = 125;
    localparam int DRAIN_CYCLES = 8;
    localparam int CW = rtpp_pkg::COORD_W;
    localparam int DIM_W = rtpp_pkg::CFG_DIM_W;
    localparam int DATA_W = rtpp_pkg::CFG_DATA_W;
    localparam logic [rtpp_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_BURSTY} rx_mode_e;

    logic                                   clk = 1'b0;
    logic                                   rst_n = 1'b0;
    logic                                   s_tvalid = 1'b0;
    logic                                   s_tready;
    logic [2*CW-1:0]                        s_tdata = '0;     // col, row
    logic                                   m_tvalid;
    logic                                   m_tready = 1'b0;
    logic [rtpp_pkg::PIXEL_W-1:0]           m_tdata;          // pixel_value
    logic                                   cfg_valid = 1'b0;
    logic                                   cfg_ready;
    logic [rtpp_pkg::CFG_IDX_W-1:0]         cfg_index = '0;
    logic [DATA_W-1:0]                      cfg_data = '0;

    int errors;
    int outstanding;
    int idle_cycles = 0;
    int burst_left = 0;
    bit gaps_on = 1'b1;
    int frame_cols = rtpp_pkg::RESET_WIDTH;
    int frame_rows = rtpp_pkg::RESET_HEIGHT;
    logic [7:0] ready_cycle = '0;
    rx_mode_e ready_mode = RX_OPEN;

    ring_test_pattern_pixel #(
        .MAX_DIM(DIM_LIMIT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    ring_pixel_checker #(
        .MAX_DIM(DIM_LIMIT)
    ) pixel_check (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .errors(errors),
        .outstanding(outstanding)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        ready_cycle <= ready_cycle + 8'd1;
        if (ready_cycle[6:0] == 7'd0)
            ready_mode <= rx_mode_e'($urandom_range(0, 3));
        case (ready_mode)
            RX_OPEN: m_tready <= 1'b1;
            RX_RANDOM: m_tready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_tready <= (ready_cycle[2:0] == 3'd0);
            RX_BURSTY: m_tready <= (ready_cycle[4:0] >= 5'd20);
            default: m_tready <= 1'b1;
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles == IDLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_pixel(input logic [CW-1:0] col, input logic [CW-1:0] row);
        if (burst_left == 0)
        begin
            if (gaps_on)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {row, col};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [rtpp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic write_frame(input logic [DATA_W-1:0] w, input logic [DATA_W-1:0] h,
                               input logic [DATA_W-1:0] t, input bit poke_unused);
        write_reg(rtpp_pkg::REG_FRAME_WIDTH, w);
        write_reg(rtpp_pkg::REG_FRAME_HEIGHT, h);
        write_reg(rtpp_pkg::REG_FRAME_TIME, t);
        if (poke_unused)
            write_reg(REG_UNUSED, $urandom);
        cfg_valid <= 1'b0;
        frame_cols = (w[DIM_W-1:0] > DIM_LIMIT) ? DIM_LIMIT : int'(w[DIM_W-1:0]);
        frame_rows = (h[DIM_W-1:0] > DIM_LIMIT) ? DIM_LIMIT : int'(h[DIM_W-1:0]);
    endtask

    function automatic logic [DATA_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 32'd1;
            2: return 32'(DIM_LIMIT);
            3: return 32'($urandom_range(DIM_LIMIT, 8191));
            4: return $urandom;
            5: return 32'($urandom_range(1, 64));
            default: return 32'($urandom_range(16, DIM_LIMIT));
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_time();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic pick_pixel(output logic [CW-1:0] col, output logic [CW-1:0] row);
        int cx;
        int cy;
        int span;
        int d;
        int e;
        cx = frame_cols / 2;
        cy = frame_rows / 2;
        span = (cx < cy) ? cx : cy;
        case ($urandom_range(0, 9))
            0:
            begin
                col = CW'($urandom);
                row = CW'($urandom);
            end
            1:
            begin
                col = CW'($urandom);
                row = CW'(int'(col) + int'($urandom_range(0, 14)) - 7);
            end
            2:
            begin
                col = CW'($urandom);
                row = CW'(frame_rows - int'(col) + int'($urandom_range(0, 14)) - 7);
            end
            3, 4:
            begin
                // Walk out from the center across the disc, ring and outer bands.
                d = $urandom_range(0, span + 4);
                if ($urandom_range(0, 1))
                    d = -d;
                e = int'($urandom_range(0, 6)) - 3;
                if ($urandom_range(0, 1))
                begin
                    col = CW'(cx + d);
                    row = CW'(cy + e);
                end
                else
                begin
                    col = CW'(cx + e);
                    row = CW'(cy + d);
                end
            end
            default:
            begin
                if (frame_cols == 0)
                    col = CW'($urandom);
                else
                    col = CW'($urandom_range(0, frame_cols - 1));
                if (frame_rows == 0)
                    row = CW'($urandom);
                else
                    row = CW'($urandom_range(0, frame_rows - 1));
            end
        endcase
    endtask

    initial
    begin
        logic [CW-1:0] col;
        logic [CW-1:0] row;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset frame of 640 by 480: outer radius 232, inner radius 200.
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd320, 12'd240);
        send_pixel(12'd320, 12'd41);
        send_pixel(12'd320, 12'd40);
        send_pixel(12'd320, 12'd30);
        send_pixel(12'd320, 12'd9);
        send_pixel(12'd320, 12'd8);
        send_pixel(12'd100, 12'd100);
        send_pixel(12'd100, 12'd106);
        send_pixel(12'd100, 12'd107);
        send_pixel(12'd100, 12'd380);
        send_pixel(12'd100, 12'd386);
        send_pixel(12'd100, 12'd387);
        send_pixel(12'd1000, 12'd100);
        wait_drained();

        write_frame(32'd1, 32'd1, 32'hffff_ffff, 1'b0);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd1, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        wait_drained();

        // Zero-sized frame: both radii negative.
        write_frame(32'd0, 32'd0, 32'h8000_0040, 1'b1);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd5, 12'd5);
        send_pixel(12'd7, 12'd0);
        wait_drained();

        // Width saturates at the maximum; height keeps only its low bits.
        write_frame(32'hffff_ffff, 32'h0000_2005, 32'h1234_5678, 1'b1);
        send_pixel(12'd2048, 12'd2);
        send_pixel(12'd4095, 12'd2);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_drained();
            write_frame(pick_dim(), pick_dim(), pick_time(), $urandom_range(0, 3) == 0);
            gaps_on = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                pick_pixel(col, row);
                send_pixel(col, row);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
